@@ design/bbt_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, codes, reset values and saturation helpers of the trajectory unit.
package bbt_pkg;

  localparam int PosW   = 15;
  localparam int SpdW   = 19;
  localparam int TimeW  = 26;
  localparam int CfgW   = 17;
  localparam int IdxW   = 3;
  localparam int MulAW  = 38;
  localparam int MulBW  = 26;
  localparam int MulPW  = 56;
  localparam int RadW   = 38;
  localparam int RootW  = 19;
  localparam int RemW   = 21;
  localparam int RootCntW = 5;

  localparam logic [IdxW-1:0] REG_GRAVITY     = 3'd0;
  localparam logic [IdxW-1:0] REG_RESTITUTION = 3'd1;
  localparam logic [IdxW-1:0] REG_TIME_STEP   = 3'd2;
  localparam logic [IdxW-1:0] REG_TIME_LIMIT  = 3'd3;
  localparam logic [IdxW-1:0] REG_LEFT_WALL   = 3'd4;
  localparam logic [IdxW-1:0] REG_RIGHT_WALL  = 3'd5;
  localparam logic [IdxW-1:0] REG_FLOOR_LEVEL = 3'd6;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] SIDE_NONE  = 2'd0;
  localparam logic [1:0] SIDE_LEFT  = 2'd1;
  localparam logic [1:0] SIDE_FLOOR = 2'd2;
  localparam logic [1:0] SIDE_RIGHT = 2'd3;

  localparam logic [15:0] GRAVITY_RST     = 16'd11133;
  localparam logic [16:0] RESTITUTION_RST = 17'd65536;
  localparam logic [15:0] TIME_STEP_RST   = 16'd3932;
  localparam logic [9:0]  TIME_LIMIT_RST  = 10'd1000;
  localparam logic [9:0]  LEFT_WALL_RST   = 10'd196;
  localparam logic [9:0]  RIGHT_WALL_RST  = 10'd584;
  localparam logic [9:0]  FLOOR_LEVEL_RST = 10'd553;

  function automatic logic signed [PosW-1:0] sat_pos(input logic signed [39:0] v);
    if (v > 40'sd16383) begin
      return 15'sh3FFF;
    end else if (v < -40'sd16384) begin
      return 15'sh4000;
    end
    return $signed(v[PosW-1:0]);
  endfunction

  function automatic logic signed [SpdW-1:0] sat_spd(input logic signed [39:0] v);
    if (v > 40'sd262143) begin
      return 19'sh3FFFF;
    end else if (v < -40'sd262144) begin
      return 19'sh40000;
    end
    return $signed(v[SpdW-1:0]);
  endfunction

endpackage

@@ design/bbt_mul.sv @@
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier, one multiplier bit per cycle, early finish.
module bbt_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bbt_pkg::MulAW-1:0] a,
  input  logic [bbt_pkg::MulBW-1:0] b,
  output logic                      busy,
  output logic                      done,
  output logic [bbt_pkg::MulPW-1:0] prod
);

  logic [bbt_pkg::MulPW-1:0] areg;
  logic [bbt_pkg::MulBW-1:0] breg;

  assign done = busy && (breg == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      areg <= bbt_pkg::MulPW'(a);
      breg <= b;
      prod <= '0;
    end else if (busy) begin
      if (breg == '0) begin
        busy <= 1'b0;
      end else begin
        if (breg[0]) begin
          prod <= prod + areg;
        end
        areg <= {areg[bbt_pkg::MulPW-2:0], 1'b0};
        breg <= {1'b0, breg[bbt_pkg::MulBW-1:1]};
      end
    end
  end

  a_done_drops: assert property (@(posedge clk) disable iff (rst) done && !start |=> !busy)
    else $error("multiplier stays busy after finishing");

endmodule

@@ design/bbt_sqrt.sv @@
`timescale 1ns / 1ps
// Digit-serial floor square root, two radicand bits and one root bit per cycle.
module bbt_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bbt_pkg::RadW-1:0]   rad,
  output logic                       busy,
  output logic                       done,
  output logic [bbt_pkg::RootW-1:0]  root
);

  logic [bbt_pkg::RadW-1:0]     radreg;
  logic [bbt_pkg::RemW-1:0]     rem;
  logic [bbt_pkg::RootCntW-1:0] cnt;
  logic [bbt_pkg::RemW+1:0]     rem_sh;
  logic [bbt_pkg::RemW+1:0]     trial;

  assign rem_sh = {rem, radreg[bbt_pkg::RadW-1 -: 2]};
  assign trial  = (bbt_pkg::RemW+2)'({root, 2'b01});
  assign done   = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy   <= 1'b1;
      radreg <= rad;
      rem    <= '0;
      root   <= '0;
      cnt    <= bbt_pkg::RootCntW'(bbt_pkg::RootW);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        radreg <= {radreg[bbt_pkg::RadW-3:0], 2'b00};
        cnt    <= cnt - 1'b1;
        if (rem_sh >= trial) begin
          rem  <= bbt_pkg::RemW'(rem_sh - trial);
          root <= {root[bbt_pkg::RootW-2:0], 1'b1};
        end else begin
          rem  <= bbt_pkg::RemW'(rem_sh);
          root <= {root[bbt_pkg::RootW-2:0], 1'b0};
        end
      end
    end
  end

  a_root_done: assert property (@(posedge clk) disable iff (rst) done && !start |=> !busy)
    else $error("square root stays busy after finishing");

endmodule

@@ design/bouncing_ball_trajectory_unit.sv @@
`timescale 1ns / 1ps
// Top level of the bouncing ball trajectory unit: sequencer, state and handshakes.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   input    | in_valid / in_ready  | op, start_x, start_y, start_speed
//   output   | out_valid/ out_ready | pos_x, pos_y, bounce_side, moving
//   config   | cfg_write            | cfg_index, cfg_data
//
// A start word, or a tick before any start, goes straight to the output register; a
// tick past the limit first updates the time. Any other tick runs four products on the
// bit-serial multiplier, a wall bounce adds two more, and a floor bounce adds three
// more and the square root.
// Synchronous reset clears state and restores the register defaults.
// A new word is taken as soon as the sequencer is idle; a result waiting in the
// output register holds only the final transfer of the next word.
module bouncing_ball_trajectory_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             op,
  input  logic signed [bbt_pkg::PosW-1:0]  start_x,
  input  logic signed [bbt_pkg::PosW-1:0]  start_y,
  input  logic signed [bbt_pkg::SpdW-1:0]  start_speed,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [bbt_pkg::PosW-1:0]  pos_x,
  output logic signed [bbt_pkg::PosW-1:0]  pos_y,
  output logic [1:0]                       bounce_side,
  output logic                             moving,
  input  logic                             cfg_write,
  input  logic [bbt_pkg::IdxW-1:0]         cfg_index,
  input  logic [bbt_pkg::CfgW-1:0]         cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_TIME, S_TT, S_GT, S_VX, S_VY, S_POS, S_WX, S_WY,
    S_FSQ, S_FG, S_FRT, S_FRS, S_OUT
  } state_t;

  state_t state;

  logic [15:0] gravity;
  logic [16:0] restitution;
  logic [15:0] time_step;
  logic [9:0]  time_limit;
  logic [9:0]  left_wall;
  logic [9:0]  right_wall;
  logic [9:0]  floor_level;

  logic signed [bbt_pkg::PosW-1:0] x0, y0, cur_x, cur_y;
  logic signed [bbt_pkg::SpdW-1:0] vx, vy;
  logic [bbt_pkg::TimeW-1:0]       et, t;
  logic                            running;
  logic [36:0]                     tsq, gt, sq;
  logic signed [30:0]              ya;
  logic [15:0]                     dmag2;
  logic                            dneg;
  logic [bbt_pkg::RadW-1:0]        rad;
  logic [bbt_pkg::RootW-1:0]       m;
  logic                            issued;
  logic [1:0]                      side;
  logic                            mov;

  logic                            mul_start, mul_busy, mul_done;
  logic [bbt_pkg::MulAW-1:0]       mul_a;
  logic [bbt_pkg::MulBW-1:0]       mul_b;
  logic [bbt_pkg::MulPW-1:0]       mul_prod;
  logic                            sqrt_start, sqrt_busy, sqrt_done;
  logic [bbt_pkg::RootW-1:0]       sqrt_root;

  logic [bbt_pkg::MulPW-1:0]       rnd16, rnd17;
  logic [18:0]                     vx_mag, vy_mag;
  logic [26:0]                     t_sum;
  logic [bbt_pkg::TimeW-1:0]       t_new;
  logic signed [30:0]              px_s, x_sum, y_part;
  logic signed [39:0]              y_full;
  logic signed [bbt_pkg::PosW-1:0] x_sat, y_sat;
  logic signed [bbt_pkg::PosW-1:0] rw, lw, fl;
  logic signed [16:0]              d_w;
  logic [16:0]                     d_mag;
  logic signed [39:0]              wall_vx, wall_vy, floor_vy;
  logic [bbt_pkg::RadW-1:0]        rad_w;
  logic                            out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  assign rnd16  = (mul_prod + bbt_pkg::MulPW'(32'h8000)) >> 16;
  assign rnd17  = (mul_prod + bbt_pkg::MulPW'(32'h10000)) >> 17;
  assign vx_mag = vx[bbt_pkg::SpdW-1] ? 19'(~vx + 19'sd1) : 19'(vx);
  assign vy_mag = vy[bbt_pkg::SpdW-1] ? 19'(~vy + 19'sd1) : 19'(vy);
  assign t_sum  = 27'(et) + 27'(time_step);
  assign t_new  = t_sum[26] ? '1 : t_sum[25:0];

  assign px_s   = $signed({2'b00, rnd16[28:0]});
  assign x_sum  = 31'(x0) + (vx[bbt_pkg::SpdW-1] ? -px_s : px_s);
  assign y_part = 31'(y0) + (vy[bbt_pkg::SpdW-1] ? -px_s : px_s);
  assign x_sat  = bbt_pkg::sat_pos(40'(x_sum));
  assign y_full = 40'(ya) + $signed({3'b000, gt});
  assign y_sat  = bbt_pkg::sat_pos(y_full);

  assign rw = $signed({1'b0, right_wall, 4'b0000});
  assign lw = $signed({1'b0, left_wall, 4'b0000});
  assign fl = $signed({1'b0, floor_level, 4'b0000});

  assign d_w   = 17'(fl) - 17'(y0);
  assign d_mag = d_w[16] ? 17'(-d_w) : 17'(d_w);

  assign wall_vx  = vx[bbt_pkg::SpdW-1] ? $signed({21'd0, rnd16[18:0]})
                                        : -$signed({21'd0, rnd16[18:0]});
  assign wall_vy  = 40'(vy) + $signed({13'd0, rnd16[26:0]});
  assign floor_vy = -$signed({20'd0, rnd16[19:0]});

  always_comb begin
    if (dneg) begin
      rad_w = ({1'b0, sq} >= bbt_pkg::RadW'(mul_prod[31:0]))
              ? ({1'b0, sq} - bbt_pkg::RadW'(mul_prod[31:0])) : '0;
    end else begin
      rad_w = {1'b0, sq} + bbt_pkg::RadW'(mul_prod[31:0]);
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_TT:    begin mul_a = bbt_pkg::MulAW'(t);           mul_b = t;                         end
      S_GT:    begin mul_a = bbt_pkg::MulAW'(tsq);         mul_b = bbt_pkg::MulBW'(gravity);  end
      S_VX:    begin mul_a = bbt_pkg::MulAW'(t);           mul_b = bbt_pkg::MulBW'(vx_mag);   end
      S_VY:    begin mul_a = bbt_pkg::MulAW'(t);           mul_b = bbt_pkg::MulBW'(vy_mag);   end
      S_WX:    begin mul_a = bbt_pkg::MulAW'(restitution); mul_b = bbt_pkg::MulBW'(vx_mag);   end
      S_WY:    begin mul_a = bbt_pkg::MulAW'(t);           mul_b = bbt_pkg::MulBW'(gravity);  end
      S_FSQ:   begin mul_a = bbt_pkg::MulAW'(vy_mag);      mul_b = bbt_pkg::MulBW'(vy_mag);   end
      S_FG:    begin mul_a = bbt_pkg::MulAW'(dmag2);       mul_b = bbt_pkg::MulBW'(gravity);  end
      S_FRS:   begin mul_a = bbt_pkg::MulAW'(restitution); mul_b = bbt_pkg::MulBW'(m);        end
      default: begin mul_a = '0;                           mul_b = '0;                        end
    endcase
  end

  always_comb begin
    case (state) inside
      S_TT, S_GT, S_VX, S_VY, S_WX, S_WY, S_FSQ, S_FG, S_FRS: mul_start = !issued;
      default: mul_start = 1'b0;
    endcase
  end

  assign sqrt_start = (state == S_FRT) && !issued;

  bbt_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  bbt_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   (rad),
    .busy  (sqrt_busy),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity     <= bbt_pkg::GRAVITY_RST;
      restitution <= bbt_pkg::RESTITUTION_RST;
      time_step   <= bbt_pkg::TIME_STEP_RST;
      time_limit  <= bbt_pkg::TIME_LIMIT_RST;
      left_wall   <= bbt_pkg::LEFT_WALL_RST;
      right_wall  <= bbt_pkg::RIGHT_WALL_RST;
      floor_level <= bbt_pkg::FLOOR_LEVEL_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bbt_pkg::REG_GRAVITY:     gravity     <= cfg_data[15:0];
        bbt_pkg::REG_RESTITUTION: restitution <= cfg_data;
        bbt_pkg::REG_TIME_STEP:   time_step   <= cfg_data[15:0];
        bbt_pkg::REG_TIME_LIMIT:  time_limit  <= cfg_data[9:0];
        bbt_pkg::REG_LEFT_WALL:   left_wall   <= cfg_data[9:0];
        bbt_pkg::REG_RIGHT_WALL:  right_wall  <= cfg_data[9:0];
        bbt_pkg::REG_FLOOR_LEVEL: floor_level <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      issued    <= 1'b0;
      running   <= 1'b0;
      x0        <= '0;
      y0        <= '0;
      vx        <= '0;
      vy        <= '0;
      et        <= '0;
      cur_x     <= '0;
      cur_y     <= '0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (op == bbt_pkg::OP_START) begin
              x0      <= start_x;
              y0      <= start_y;
              vx      <= start_speed;
              vy      <= '0;
              et      <= '0;
              running <= 1'b1;
              cur_x   <= start_x;
              cur_y   <= start_y;
              side    <= bbt_pkg::SIDE_NONE;
              mov     <= 1'b1;
              state   <= S_OUT;
            end else if (running) begin
              state <= S_TIME;
            end else begin
              side  <= bbt_pkg::SIDE_NONE;
              mov   <= 1'b0;
              state <= S_OUT;
            end
          end
        end
        S_TIME: begin
          et   <= t_new;
          t    <= t_new;
          side <= bbt_pkg::SIDE_NONE;
          if (t_new <= {time_limit, 16'h0000}) begin
            mov   <= 1'b1;
            state <= S_TT;
          end else begin
            mov   <= 1'b0;
            state <= S_OUT;
          end
        end
        S_TT, S_GT, S_VX, S_VY, S_WX, S_WY, S_FSQ, S_FG, S_FRS: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (mul_done) begin
            issued <= 1'b0;
            unique case (state)
              S_TT:  begin tsq <= rnd16[36:0]; state <= S_GT; end
              S_GT:  begin gt <= rnd17[36:0]; state <= S_VX; end
              S_VX:  begin cur_x <= x_sat; state <= S_VY; end
              S_VY:  begin ya <= y_part; state <= S_POS; end
              S_WX:  begin vx <= bbt_pkg::sat_spd(wall_vx); state <= S_WY; end
              S_WY:  begin vy <= bbt_pkg::sat_spd(wall_vy); state <= S_OUT; end
              S_FSQ: begin sq <= mul_prod[36:0]; state <= S_FG; end
              S_FG:  begin rad <= rad_w; state <= S_FRT; end
              S_FRS: begin vy <= bbt_pkg::sat_spd(floor_vy); state <= S_OUT; end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_POS: begin
          if (cur_x > rw || cur_x < lw) begin
            cur_y <= y_sat;
            side  <= (cur_x > rw) ? bbt_pkg::SIDE_RIGHT : bbt_pkg::SIDE_LEFT;
            cur_x <= (cur_x > rw) ? rw : lw;
            x0    <= (cur_x > rw) ? rw : lw;
            y0    <= y_sat;
            et    <= '0;
            state <= S_WX;
          end else if (y_sat > fl) begin
            side  <= bbt_pkg::SIDE_FLOOR;
            cur_y <= fl;
            dneg  <= d_w[16];
            dmag2 <= {d_mag[14:0], 1'b0};
            x0    <= cur_x;
            y0    <= fl;
            et    <= '0;
            state <= S_FSQ;
          end else begin
            cur_y <= y_sat;
            state <= S_OUT;
          end
        end
        S_FRT: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (sqrt_done) begin
            issued <= 1'b0;
            m      <= sqrt_root;
            state  <= S_FRS;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            pos_x       <= cur_x;
            pos_y       <= cur_y;
            bounce_side <= side;
            moving      <= mov;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_mul_free: assert property (@(posedge clk) disable iff (rst) mul_start |-> !mul_busy)
    else $error("multiply issued while the multiplier is busy");

  a_sqrt_free: assert property (@(posedge clk) disable iff (rst) sqrt_start |-> !sqrt_busy)
    else $error("square root issued while busy");

  a_out_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> !mul_busy && !sqrt_busy)
    else $error("result published while arithmetic still runs");

  a_side_moving: assert property (@(posedge clk) disable iff (rst)
    out_valid && bounce_side != bbt_pkg::SIDE_NONE |-> moving)
    else $error("bounce reported on a stopped ball");

endmodule
